// File: hdl/pswr_pkg.sv
// ----------------------------------------------------------------------------
// pswr_pkg: shared types and constants of the palette scan-out raster block
// payload structs, item kinds, register indexes and the wave offset table
// ----------------------------------------------------------------------------
package pswr_pkg;

	localparam logic [1:0] KIND_PIXEL   = 2'd0;
	localparam logic [1:0] KIND_FLUSH   = 2'd1;
	localparam logic [1:0] KIND_PALETTE = 2'd2;

	localparam logic [1:0] TINT_NONE = 2'd0;
	localparam logic [1:0] TINT_BLUE = 2'd1;

	localparam int COMP_W = 6;
	localparam logic [COMP_W:0] TINT_ADD = 7'd40;
	localparam logic [COMP_W:0] COMP_MAX = 7'd63;

	localparam int WAVE_LEN = 24;
	localparam logic [4:0] PHASE_MAX = 5'd23;
	localparam logic [4:0] PHASE_LEN = 5'd24;

	localparam int QDEPTH = 4;

	localparam logic [10:0] LINE_WIDTH_RESET = 11'd640;
	localparam logic [10:0] LINE_WIDTH_MIN   = 11'd3;

	typedef enum logic [1:0] {
		CFG_LINE_WIDTH = 2'd0,
		CFG_WAVE_ON    = 2'd1,
		CFG_RASTER_ON  = 2'd2,
		CFG_TINT_MODE  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [10:0] line_width;
		logic        wave_on;
		logic        raster_on;
		logic [1:0]  tint_mode;
	} cfg_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       frame_start;
		logic [4:0] wave_phase;
		logic [7:0] index;
		logic [5:0] red;
		logic [5:0] green;
		logic [5:0] blue;
	} pswr_in_t;

	typedef struct packed {
		logic [23:0] color;
		logic        line_end;
	} pswr_out_t;

	// one request handed from the front to the back
	typedef struct packed {
		logic        pal_wr;
		logic        blank;
		logic        last;
		logic [7:0]  index;
		logic [17:0] rgb;
	} q_entry_t;

	localparam logic signed [2:0] WAVE_TABLE [WAVE_LEN] = '{
		3'sd0, 3'sd1, 3'sd1, 3'sd1, 3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd1, 3'sd1,
		3'sd0, -3'sd1, -3'sd1, -3'sd1, -3'sd1, -3'sd2, -3'sd2, -3'sd2, -3'sd2, -3'sd1,
		-3'sd1, -3'sd1
	};

endpackage

// File: hdl/pswr_ram.sv
// ----------------------------------------------------------------------------
// pswr_ram: generic single-write, single-read memory
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module pswr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/pswr_front.sv
// ----------------------------------------------------------------------------
// pswr_front: raster tracking and line buffering
// tracks column, row parity and wave index, writes the load bank and
// reads the pending line rotated by its offset, then queues one request
// ----------------------------------------------------------------------------
module pswr_front import pswr_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  pswr_in_t in_data,
	output logic     q_valid,
	input  logic     q_ready,
	output q_entry_t q_data
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int CMPW = (WW > 11) ? WW : 11;
	localparam int AW   = CW + 1;

	logic [CW-1:0]     column_q;
	logic              load_bank_q;
	logic              row_odd_q;
	logic [4:0]        wave_index_q;
	logic              pending_valid_q;
	logic signed [2:0] pending_offset_q;
	logic              pending_blank_q;

	logic              s1_valid_q;
	logic              s1_pal_s1;
	logic              s1_blank_s1;
	logic              s1_last_s1;
	logic [7:0]        s1_index_s1;
	logic [17:0]       s1_rgb_s1;

	logic              accept;
	logic              is_pix;
	logic              is_line;
	logic              fs;
	logic [CW-1:0]     col_sel;
	logic              row_odd_sel;
	logic              pend_sel;
	logic [4:0]        widx_sel;
	logic [CMPW-1:0]   lw_ext;
	logic [WW-1:0]     w;
	logic [WW-1:0]     wm1;
	logic [CW-1:0]     c;
	logic              last;
	logic signed [WW+1:0] sd;
	logic signed [WW+1:0] sd_adj;
	logic [CW-1:0]     s;
	logic              emit;
	logic [7:0]        line_rdata;

	assign in_ready = !s1_valid_q || q_ready;
	assign accept   = in_valid && in_ready;
	assign is_pix   = in_data.kind == KIND_PIXEL;
	assign is_line  = is_pix || (in_data.kind == KIND_FLUSH);
	assign fs       = is_pix && in_data.frame_start;

	// frame start restarts the raster before this item is placed
	always_comb begin
		col_sel     = fs ? '0 : column_q;
		row_odd_sel = fs ? 1'b0 : row_odd_q;
		pend_sel    = fs ? 1'b0 : pending_valid_q;
		if (fs) begin
			widx_sel = (in_data.wave_phase >= PHASE_LEN) ?
				in_data.wave_phase - PHASE_LEN : in_data.wave_phase;
		end else begin
			widx_sel = wave_index_q;
		end
	end

	assign lw_ext = CMPW'(cfg.line_width);

	always_comb begin
		if (lw_ext > CMPW'(MAX_WIDTH)) begin
			w = WW'(MAX_WIDTH);
		end else if (lw_ext < CMPW'(LINE_WIDTH_MIN)) begin
			w = WW'(LINE_WIDTH_MIN);
		end else begin
			w = WW'(lw_ext);
		end
	end

	assign wm1  = w - WW'(1);
	assign c    = (WW'(col_sel) >= w) ? CW'(wm1) : col_sel;
	assign last = WW'(c) == wm1;

	// source column of the pending line, wrapped once either way
	assign sd = $signed({2'b00, WW'(c)}) - (WW + 2)'(pending_offset_q);

	always_comb begin
		if (sd < 0) begin
			sd_adj = sd + $signed({2'b00, w});
		end else if (sd >= $signed({2'b00, w})) begin
			sd_adj = sd - $signed({2'b00, w});
		end else begin
			sd_adj = sd;
		end
	end

	assign s    = CW'(sd_adj);
	assign emit = is_line && pend_sel;

	pswr_ram #(
		.WIDTH (8),
		.DEPTH (2 << CW)
	) u_line_ram (
		.clk   (clk),
		.we    (accept && is_pix),
		.waddr ({load_bank_q, c}),
		.wdata (in_data.index),
		.re    (accept && emit),
		.raddr (AW'({~load_bank_q, s})),
		.rdata (line_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q         <= '0;
			load_bank_q      <= 1'b0;
			row_odd_q        <= 1'b0;
			wave_index_q     <= '0;
			pending_valid_q  <= 1'b0;
			pending_offset_q <= '0;
			pending_blank_q  <= 1'b0;
		end else if (accept && is_line) begin
			if (last) begin
				if (is_pix) begin
					pending_valid_q  <= 1'b1;
					pending_offset_q <= cfg.wave_on ? WAVE_TABLE[widx_sel] : 3'sd0;
					pending_blank_q  <= cfg.raster_on && row_odd_sel;
					load_bank_q      <= ~load_bank_q;
				end else begin
					pending_valid_q <= 1'b0;
				end
				if (row_odd_sel) begin
					wave_index_q <= (widx_sel >= PHASE_MAX) ? '0 : widx_sel + 5'd1;
				end else begin
					wave_index_q <= widx_sel;
				end
				row_odd_q <= ~row_odd_sel;
				column_q  <= '0;
			end else begin
				pending_valid_q <= pend_sel;
				wave_index_q    <= widx_sel;
				row_odd_q       <= row_odd_sel;
				column_q        <= c + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= accept && (emit || (in_data.kind == KIND_PALETTE));
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_pal_s1   <= in_data.kind == KIND_PALETTE;
			s1_blank_s1 <= pending_blank_q;
			s1_last_s1  <= last;
			s1_index_s1 <= in_data.index;
			s1_rgb_s1   <= {in_data.red, in_data.green, in_data.blue};
		end
	end

	// line data arrives with the stage register and holds while stalled
	always_comb begin
		q_valid       = s1_valid_q;
		q_data.pal_wr = s1_pal_s1;
		q_data.blank  = s1_blank_s1;
		q_data.last   = s1_last_s1;
		q_data.index  = s1_pal_s1 ? s1_index_s1 : line_rdata;
		q_data.rgb    = s1_rgb_s1;
	end

	a_column_range: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(column_q) < WW'(MAX_WIDTH))
		else $error("column beyond line buffer");

	a_wave_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		wave_index_q <= PHASE_MAX)
		else $error("wave index out of table");

	a_stall_holds_line: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !q_ready |=> $stable(line_rdata))
		else $error("line read data lost under stall");

endmodule

// File: hdl/pswr_fifo.sv
// ----------------------------------------------------------------------------
// pswr_fifo: request queue between front and back
// small register queue so either side may stall on its own
// ----------------------------------------------------------------------------
module pswr_fifo import pswr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  q_entry_t push_data,
	output logic     pop_valid,
	input  logic     pop_ready,
	output q_entry_t pop_data
);

	localparam int PW = $clog2(QDEPTH);

	q_entry_t          entry_q [QDEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       count_q;
	logic              push;
	logic              pop;

	assign push_ready = count_q != (PW + 1)'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW + 1)'(QDEPTH))
		else $error("queue overfilled");

endmodule

// File: hdl/pswr_back.sv
// ----------------------------------------------------------------------------
// pswr_back: palette lookup and colour output
// applies palette writes in order, looks up colours, tints and packs them
// into the output register
// ----------------------------------------------------------------------------
module pswr_back import pswr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	output logic      q_ready,
	input  q_entry_t  q_data,
	output logic      out_valid,
	input  logic      out_ready,
	output pswr_out_t out_data
);

	logic        b1_valid_q;
	logic        b1_blank_s1;
	logic        b1_last_s1;
	logic        out_valid_q;
	pswr_out_t   out_data_q;
	logic        adv;
	logic        pop;
	logic [17:0] pal_rdata;
	logic [5:0]  r;
	logic [5:0]  g;
	logic [5:0]  b;
	logic [6:0]  r_sum;
	logic [6:0]  b_sum;
	logic [5:0]  r_t;
	logic [5:0]  b_t;
	logic [23:0] color;

	assign adv     = !out_valid_q || out_ready;
	assign q_ready = !b1_valid_q || adv;
	assign pop     = q_valid && q_ready;

	pswr_ram #(
		.WIDTH (18),
		.DEPTH (256)
	) u_pal_ram (
		.clk   (clk),
		.we    (pop && q_data.pal_wr),
		.waddr (q_data.index),
		.wdata (q_data.rgb),
		.re    (pop && !q_data.pal_wr),
		.raddr (q_data.index),
		.rdata (pal_rdata)
	);

	assign r     = pal_rdata[17:12];
	assign g     = pal_rdata[11:6];
	assign b     = pal_rdata[5:0];
	assign r_sum = {1'b0, r} + TINT_ADD;
	assign b_sum = {1'b0, b} + TINT_ADD;

	// saturating tint, mode 3 behaves as red
	always_comb begin
		r_t = r;
		b_t = b;
		case (cfg.tint_mode)
			TINT_NONE: begin
			end
			TINT_BLUE: begin
				b_t = (b_sum > COMP_MAX) ? COMP_MAX[5:0] : b_sum[5:0];
			end
			default: begin
				r_t = (r_sum > COMP_MAX) ? COMP_MAX[5:0] : r_sum[5:0];
			end
		endcase
		color = b1_blank_s1 ? '0 : {r_t, 2'b00, g, 2'b00, b_t, 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				b1_valid_q <= !q_data.pal_wr;
			end else if (adv) begin
				b1_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= b1_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			b1_blank_s1 <= q_data.blank;
			b1_last_s1  <= q_data.last;
		end
		if (adv && b1_valid_q) begin
			out_data_q.color    <= color;
			out_data_q.line_end <= b1_last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_blank_black: assert property (@(posedge clk) disable iff (!arst_n)
		adv && b1_valid_q && b1_blank_s1 |=> out_data_q.color == '0)
		else $error("blanked row not black");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		b1_valid_q && !adv |=> b1_valid_q)
		else $error("colour request dropped under stall");

endmodule

// File: hdl/palette_scanout_wave_raster.sv
// ----------------------------------------------------------------------------
// palette_scanout_wave_raster: indexed-colour scan-out with line scroll
// top level with configuration registers, front, request queue and back
// ----------------------------------------------------------------------------
// in channel: pixel, flush and palette-write requests (in_valid/in_ready).
// pixel requests fill one line bank while the previous line is emitted,
// one colour per pixel or flush request while a line is pending, on the out channel
// (out_valid/out_ready); palette writes and kind 3 give no result.
// cfg channel: cfg_index selects line_width, wave_on, raster_on or
// tint_mode; cfg_ready is always high and each write is registered in cfg_q.
// a request passes the line ram read, the queue, the palette ram read and the
// output register in that order. throughput: one request per cycle unless the
// receiver stalls, set by the single line ram write and read port used once
// per request and one palette ram access per request. a stalled receiver
// first fills the output register and back stage, then the four-entry queue
// and the front stage; only then does in_ready drop.
// reset clears raster position, pending line and queue; line and palette
// memories are not cleared and must be written before being shown.
// ----------------------------------------------------------------------------
module palette_scanout_wave_raster import pswr_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  pswr_in_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output pswr_out_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [10:0] cfg_data
);

	cfg_t     cfg_q;
	logic     q_push_valid;
	logic     q_push_ready;
	q_entry_t q_push_data;
	logic     q_pop_valid;
	logic     q_pop_ready;
	q_entry_t q_pop_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_width <= LINE_WIDTH_RESET;
			cfg_q.wave_on    <= 1'b0;
			cfg_q.raster_on  <= 1'b0;
			cfg_q.tint_mode  <= TINT_NONE;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_LINE_WIDTH: cfg_q.line_width <= cfg_data;
				CFG_WAVE_ON:    cfg_q.wave_on    <= cfg_data[0];
				CFG_RASTER_ON:  cfg_q.raster_on  <= cfg_data[0];
				CFG_TINT_MODE:  cfg_q.tint_mode  <= cfg_data[1:0];
			endcase
		end
	end

	pswr_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_push_valid),
		.q_ready  (q_push_ready),
		.q_data   (q_push_data)
	);

	pswr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data)
	);

	pswr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_pop_valid),
		.q_ready   (q_pop_ready),
		.q_data    (q_pop_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: sim/tb_palette_scanout_wave_raster.sv
// ----------------------------------------------------------------------------
// tb_palette_scanout_wave_raster: self-checking bench for the palette scan-out
// a queue-fed driver sends pixel, flush, palette-write and kind 3 requests across a
// series of register settings. The monitor keeps its own raster and palette
// state, predicts every emitted colour and compares it in order with what the
// block returns, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_palette_scanout_wave_raster;
	timeunit 1ns;
	timeprecision 1ps;
	import pswr_pkg::*;

	localparam int MAX_W = 1024;
	localparam int LAT_PAUSE = 8;
	localparam int N_SHOWN = 10;
	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam logic [1:0] TINT_RED = 2'd2;
	localparam logic [1:0] TINT_RED_ALT = 2'd3;

	typedef struct packed {
		cfg_reg_t    sel;
		logic [10:0] value;
	} reg_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	pswr_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	pswr_out_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [10:0] cfg_data = '0;

	pswr_in_t   scan_queue [$];
	reg_write_t reg_queue [$];
	pswr_out_t  due_pixels [$];

	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int n_bad = 0;

	// predicted block state
	logic [10:0] m_width;
	logic        m_wave, m_raster;
	logic [1:0]  m_tint;
	logic [7:0]  m_line [2*MAX_W];
	logic [17:0] m_pal [256];
	int          m_col, m_widx, m_poff;
	bit          m_bank, m_odd, m_pend, m_pblank;

	// stimulus side: column being loaded and how many banks hold a full line
	int g_w = int'(LINE_WIDTH_RESET);
	int g_col = 0;
	int g_fill = 0;

	palette_scanout_wave_raster #(.MAX_WIDTH(MAX_W)) u_top (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_data,
		.out_valid,
		.out_ready,
		.out_data,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int clamp_width(input logic [10:0] w);
		if (w > MAX_W)
			return MAX_W;
		if (w < LINE_WIDTH_MIN)
			return int'(LINE_WIDTH_MIN);
		return int'(w);
	endfunction

	function automatic logic [23:0] shade(input logic [7:0] idx);
		logic [6:0] r, g, b;
		r = {1'b0, m_pal[idx][17:12]};
		g = {1'b0, m_pal[idx][11:6]};
		b = {1'b0, m_pal[idx][5:0]};
		if (m_tint == TINT_BLUE) begin
			b = (b + TINT_ADD > COMP_MAX) ? COMP_MAX : b + TINT_ADD;
		end else if (m_tint != TINT_NONE) begin
			r = (r + TINT_ADD > COMP_MAX) ? COMP_MAX : r + TINT_ADD;
		end
		return {r[5:0], 2'b00, g[5:0], 2'b00, b[5:0], 2'b00};
	endfunction

	task automatic advance_raster(input pswr_in_t it);
		int w, c, s;
		bit last;
		pswr_out_t px;
		if (it.kind == KIND_PALETTE)
			m_pal[it.index] = {it.red, it.green, it.blue};
		if (it.kind != KIND_PIXEL && it.kind != KIND_FLUSH)
			return;
		if (it.kind == KIND_PIXEL && it.frame_start) begin
			m_col = 0;
			m_odd = 0;
			m_pend = 0;
			m_widx = int'((it.wave_phase >= PHASE_LEN) ?
				it.wave_phase - PHASE_LEN : it.wave_phase);
		end
		w = clamp_width(m_width);
		c = (m_col >= w) ? w - 1 : m_col;
		last = (c == w - 1);
		if (m_pend) begin
			px.color = '0;
			if (!m_pblank) begin
				s = c - m_poff;
				if (s < 0)
					s += w;
				if (s >= w)
					s -= w;
				px.color = shade(m_line[(m_bank ? 0 : MAX_W) + s]);
			end
			px.line_end = last;
			due_pixels.push_back(px);
		end
		if (it.kind == KIND_PIXEL)
			m_line[(m_bank ? MAX_W : 0) + c] = it.index;
		if (last) begin
			if (it.kind == KIND_PIXEL) begin
				m_pend = 1;
				m_poff = m_wave ? int'(WAVE_TABLE[m_widx]) : 0;
				m_pblank = m_raster && m_odd;
				m_bank = !m_bank;
			end else begin
				m_pend = 0;
			end
			if (m_odd)
				m_widx = (m_widx >= PHASE_MAX) ? 0 : m_widx + 1;
			m_odd = !m_odd;
			m_col = 0;
		end else begin
			m_col = c + 1;
		end
	endtask

	// driver: request and register-write channels, receiver stalls
	always @(posedge clk or negedge arst_n) begin
		reg_write_t wr;
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (!in_valid || in_ready) begin
				if (scan_queue.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= scan_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= out_idle_pct);
			if (!cfg_valid || cfg_ready) begin
				if (reg_queue.size() != 0) begin
					wr = reg_queue.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= wr.sel;
					cfg_data <= wr.value;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: predicts on accepted requests, checks every emitted pixel
	always @(posedge clk or negedge arst_n) begin
		pswr_out_t want;
		if (!arst_n) begin
			m_width = LINE_WIDTH_RESET;
			m_wave = 1'b0;
			m_raster = 1'b0;
			m_tint = TINT_NONE;
			m_col = 0;
			m_widx = 0;
			m_poff = 0;
			m_bank = 0;
			m_odd = 0;
			m_pend = 0;
			m_pblank = 0;
			due_pixels.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_LINE_WIDTH: m_width = cfg_data;
					CFG_WAVE_ON:    m_wave = cfg_data[0];
					CFG_RASTER_ON:  m_raster = cfg_data[0];
					CFG_TINT_MODE:  m_tint = cfg_data[1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				advance_raster(in_data);
			if (out_valid && out_ready) begin
				if (due_pixels.size() == 0) begin
					n_bad++;
					if (n_bad <= N_SHOWN)
						$display("unexpected pixel: colour %06h line_end %0b",
							out_data.color, out_data.line_end);
				end else begin
					want = due_pixels.pop_front();
					if (out_data.color !== want.color || out_data.line_end !== want.line_end) begin
						n_bad++;
						if (n_bad <= N_SHOWN)
							$display("pixel mismatch: expected colour %06h line_end %0b, got colour %06h line_end %0b",
								want.color, want.line_end, out_data.color, out_data.line_end);
					end
				end
			end
		end
	end

	function automatic pswr_in_t make_item(input logic [1:0] kind, input logic fs,
			input logic [4:0] phase, input logic [7:0] idx, input logic [5:0] r = '0,
			input logic [5:0] g = '0, input logic [5:0] b = '0);
		pswr_in_t it;
		it.kind = kind;
		it.frame_start = fs;
		it.wave_phase = phase;
		it.index = idx;
		it.red = r;
		it.green = g;
		it.blue = b;
		return it;
	endfunction

	task automatic add_item(input pswr_in_t it);
		int c;
		scan_queue.push_back(it);
		if (it.kind == KIND_PIXEL && it.frame_start)
			g_col = 0;
		if (it.kind == KIND_PIXEL || it.kind == KIND_FLUSH) begin
			c = (g_col >= g_w) ? g_w - 1 : g_col;
			if (c == g_w - 1) begin
				if (it.kind == KIND_PIXEL && g_fill < 2)
					g_fill++;
				g_col = 0;
			end else begin
				g_col = c + 1;
			end
		end
	endtask

	task automatic add_random_items(input int n_req);
		int n, pick, c;
		pswr_in_t it;
		n = 0;
		while (n < n_req) begin
			pick = $urandom_range(99);
			it = make_item(KIND_PIXEL, 1'b0, 5'($urandom_range(31)), 8'($urandom),
				6'($urandom), 6'($urandom), 6'($urandom));
			c = (g_col >= g_w) ? g_w - 1 : g_col;
			if (pick < 8) begin
				// a flush mid-line leaves a hole, so only once both banks are full or at the last column
				if (g_fill >= 2 || c == g_w - 1) begin
					it.kind = KIND_FLUSH;
					it.frame_start = 1'($urandom_range(1));
				end
			end else if (pick < 14) begin
				it.kind = KIND_PALETTE;
				it.frame_start = 1'($urandom_range(1));
			end else if (pick < 17) begin
				it.kind = KIND_NONE;
				it.frame_start = 1'($urandom_range(1));
			end else if ($urandom_range(4 * g_w + 20) == 0) begin
				it.frame_start = 1'b1;
			end
			add_item(it);
			if (it.kind != KIND_NONE)
				n++;
		end
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (scan_queue.size() != 0 || in_valid || due_pixels.size() != 0 ||
			reg_queue.size() != 0 || cfg_valid);
		repeat (LAT_PAUSE) @(negedge clk);
	endtask

	task automatic run_phase(input logic [10:0] width, input logic wave, input logic raster,
			input logic [1:0] tint, input bit restart, input int n_rand, input int pad_gap);
		int nw;
		settle();
		reg_queue.push_back('{sel: CFG_LINE_WIDTH, value: width});
		reg_queue.push_back('{sel: CFG_WAVE_ON, value: 11'(wave)});
		reg_queue.push_back('{sel: CFG_RASTER_ON, value: 11'(raster)});
		reg_queue.push_back('{sel: CFG_TINT_MODE, value: 11'(tint)});
		nw = clamp_width(width);
		// wider lines would expose unwritten columns of both banks
		if (nw > g_w)
			g_fill = 0;
		g_w = nw;
		settle();
		if (restart)
			add_item(make_item(KIND_PIXEL, 1'b1, 5'($urandom_range(31)), 8'($urandom)));
		add_random_items(n_rand);
		// leave the line open so the next phase can narrow it under the column
		if (pad_gap > 0) begin
			while (g_col != g_w - pad_gap)
				add_item(make_item(KIND_PIXEL, 1'b0, 5'd0, 8'($urandom)));
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		in_idle_pct = 27;
		out_idle_pct = 81;
		run_phase(11'd4, 1'b1, 1'b1, TINT_RED_ALT, 1'b0, 0, 0);
		for (int i = 0; i < 256; i++)
			add_item(make_item(KIND_PALETTE, 1'b0, 5'd0, 8'(i),
				6'($urandom), 6'($urandom), 6'($urandom)));
		// phase beyond the table length wraps
		add_item(make_item(KIND_PIXEL, 1'b1, 5'd31, 8'd0));
		add_item(make_item(KIND_PIXEL, 1'b0, 5'd0, 8'd255));
		add_item(make_item(KIND_PIXEL, 1'b0, 5'd0, 8'h55));
		add_item(make_item(KIND_PIXEL, 1'b0, 5'd0, 8'hAA));
		for (int i = 1; i <= 4; i++)
			add_item(make_item(KIND_PIXEL, 1'b0, 5'd0, 8'(i)));
		add_item(make_item(KIND_PALETTE, 1'b1, 5'd0, 8'd255, 6'd63, 6'd63, 6'd63));
		add_item(make_item(KIND_PALETTE, 1'b0, 5'd0, 8'd0, 6'd0, 6'd0, 6'd0));
		add_item(make_item(KIND_NONE, 1'b1, 5'd31, 8'd255, 6'd63, 6'd63, 6'd63));
		add_item(make_item(KIND_PIXEL, 1'b0, 5'd0, 8'd255));
		// frame start on a flush request is ignored
		add_item(make_item(KIND_FLUSH, 1'b1, 5'd0, 8'd0));
		add_item(make_item(KIND_PIXEL, 1'b0, 5'd0, 8'd0));
		add_item(make_item(KIND_PIXEL, 1'b0, 5'd0, 8'd255));
		for (int i = 0; i < 3; i++)
			add_item(make_item(KIND_PIXEL, 1'b0, 5'd0, 8'(i + 9)));
		// line closed by a flush: nothing becomes pending
		add_item(make_item(KIND_FLUSH, 1'b0, 5'd0, 8'd0));
		add_item(make_item(KIND_PIXEL, 1'b1, 5'd23, 8'd255));
		add_random_items(50);
		run_phase(11'd7, 1'b1, 1'b0, TINT_BLUE, 1'b1, 50, 2);

		in_idle_pct = 81;
		out_idle_pct = 27;
		run_phase(11'd3, 1'b0, 1'b1, TINT_RED, 1'b0, 50, 0);
		run_phase(11'd0, 1'b1, 1'b1, TINT_NONE, 1'b1, 40, 0);

		in_idle_pct = 0;
		out_idle_pct = 0;
		run_phase(11'd13, 1'b1, 1'b0, TINT_RED_ALT, 1'b1, 60, 0);
		run_phase(11'd1024, 1'b1, 1'b1, TINT_BLUE, 1'b1, 20, 0);
		run_phase(11'd2047, 1'b0, 1'b0, TINT_RED, 1'b0, 10, 0);
		run_phase(11'd5, 1'b1, 1'b1, TINT_NONE, 1'b1, 40, 0);
		settle();

		if (n_bad == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
